// ===== hdl/rlsse_pkg.sv =====
`timescale 1ns / 1ps

package rlsse_pkg;

    localparam int NUM_LEDS_DEF       = 15;
    localparam int LEDS_PER_GROUP_DEF = 5;
    localparam int CHAN_COUNT         = 3;

    localparam logic [7:0] RESET_ONE_CODE  = 8'hF8;
    localparam logic [7:0] RESET_ZERO_CODE = 8'hE0;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;
    localparam logic [1:0] COLOR_NONE  = 2'd3;

    // Position of a channel within one LED's frame slot.
    localparam logic [1:0] SLOT_FIRST = 2'd0;
    localparam logic [1:0] SLOT_LAST  = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_CODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE = 1'b1;

    typedef struct packed {
        logic set_start;
        logic set_write;
        logic send_start;
        logic send_issue;
    } rlsse_cmd_t;

    typedef struct packed {
        logic set_ok;
        logic set_last;
        logic send_last;
        logic issue_ok;
    } rlsse_status_t;

    // Stored channel that goes out in a given slot: green, red, blue.
    function automatic logic [1:0] send_color(input logic [1:0] slot);
        logic [1:0] col;
        unique case (slot)
            2'd0:    col = COLOR_GREEN;
            2'd1:    col = COLOR_RED;
            default: col = COLOR_BLUE;
        endcase
        return col;
    endfunction

    // Data bit 7 maps to the most significant code byte.
    function automatic logic [63:0] encode_byte(input logic [7:0] data,
                                                input logic [7:0] one_code,
                                                input logic [7:0] zero_code);
        logic [63:0] word;
        word = '0;
        for (int j = 0; j < 8; j++)
        begin
            word[63-8*j -: 8] = data[7-j] ? one_code : zero_code;
        end
        return word;
    endfunction

endpackage

// ===== hdl/rlsse_intf.sv =====
`timescale 1ns / 1ps

interface rlsse_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [1:0] group;
    logic [1:0] color;
    logic [7:0] value;

    modport source (output valid, op, group, color, value, input ready);
    modport sink (input valid, op, group, color, value, output ready);
endinterface

interface rlsse_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  led_num;
    logic [1:0]  channel;
    logic [63:0] spi_bytes;
    logic        last;

    modport source (output valid, led_num, channel, spi_bytes, last, input ready);
    modport sink (input valid, led_num, channel, spi_bytes, last, output ready);
endinterface

interface rlsse_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rlsse_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/rlsse_ram.sv =====
`timescale 1ns / 1ps

module rlsse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 45
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rlsse_ctrl.sv =====
`timescale 1ns / 1ps

module rlsse_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_op,
    output logic                     in_ready,
    input  rlsse_pkg::rlsse_status_t status,
    output rlsse_pkg::rlsse_cmd_t    cmd
);

    import rlsse_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET_WR,
        ST_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   pending_reg, pending_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_SET)
                    begin
                        if (status.set_ok)
                        begin
                            cmd.set_start = 1'b1;
                            pending_next  = 1'b1;
                            state_next    = ST_SET_WR;
                        end
                    end
                    else if (pending_reg)
                    begin
                        cmd.send_start = 1'b1;
                        pending_next   = 1'b0;
                        state_next     = ST_SEND;
                    end
                end
            end
            ST_SET_WR:
            begin
                cmd.set_write = 1'b1;
                if (status.set_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEND:
            begin
                if (status.issue_ok)
                begin
                    cmd.send_issue = 1'b1;
                    if (status.send_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== hdl/rlsse_dp.sv =====
`timescale 1ns / 1ps

module rlsse_dp #(
    parameter int NUM_LEDS       = rlsse_pkg::NUM_LEDS_DEF,
    parameter int LEDS_PER_GROUP = rlsse_pkg::LEDS_PER_GROUP_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [1:0]               in_group,
    input  logic [1:0]               in_color,
    input  logic [7:0]               in_value,
    input  rlsse_pkg::rlsse_cmd_t    cmd,
    output rlsse_pkg::rlsse_status_t status,
    rlsse_cfg_if.sink                cfg,
    rlsse_out_if.source              words
);

    import rlsse_pkg::*;

    localparam int DEPTH  = NUM_LEDS * CHAN_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LED_W  = $clog2(NUM_LEDS);
    localparam int GRP_W  = $clog2(NUM_LEDS + 4 * LEDS_PER_GROUP + 1);

    // Configuration registers.
    logic [7:0] one_code_reg;
    logic [7:0] zero_code_reg;

    // Set walk.
    logic [GRP_W-1:0]  first;
    logic [GRP_W-1:0]  set_end;
    logic [GRP_W-1:0]  set_led_reg;
    logic [GRP_W-1:0]  set_end_reg;
    logic [ADDR_W-1:0] set_addr_reg;
    logic [7:0]        set_value_reg;

    // Send walk.
    logic [LED_W-1:0]  snd_led_reg;
    logic [1:0]        snd_slot_reg;
    logic [ADDR_W-1:0] snd_base_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              snd_last;

    // Entries written since reset; an unwritten entry reads as zero.
    logic [DEPTH-1:0]  written_reg;

    // Read stage and output word.
    logic [7:0]        ram_q;
    logic              s1_valid_reg;
    logic              s1_hit_reg;
    logic [LED_W-1:0]  s1_led_reg;
    logic [1:0]        s1_slot_reg;
    logic              s1_last_reg;
    logic              advance;
    logic [LED_W+3:0]  led_ext;
    logic [7:0]        byte_data;

    logic              out_valid_reg;
    logic [3:0]        out_led_reg;
    logic [1:0]        out_chan_reg;
    logic [63:0]       out_bytes_reg;
    logic              out_last_reg;

    always_comb
    begin
        first = GRP_W'(int'(in_group) * LEDS_PER_GROUP);
        if (int'(first) + LEDS_PER_GROUP > NUM_LEDS)
        begin
            set_end = GRP_W'(NUM_LEDS - 1);
        end
        else
        begin
            set_end = GRP_W'(int'(first) + LEDS_PER_GROUP - 1);
        end
    end

    assign rd_addr  = snd_base_reg + ADDR_W'(send_color(snd_slot_reg));
    assign snd_last = (snd_led_reg == LED_W'(NUM_LEDS - 1)) && (snd_slot_reg == SLOT_LAST);
    assign advance  = s1_valid_reg && (!out_valid_reg || words.ready);

    assign status.set_ok    = (in_color != COLOR_NONE) && (int'(first) < NUM_LEDS);
    assign status.set_last  = (set_led_reg == set_end_reg);
    assign status.send_last = snd_last;
    assign status.issue_ok  = !s1_valid_reg || advance;

    rlsse_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.set_write),
        .waddr (set_addr_reg),
        .wdata (set_value_reg),
        .re    (cmd.send_issue),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_code_reg  <= RESET_ONE_CODE;
            zero_code_reg <= RESET_ZERO_CODE;
            written_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_ONE_CODE:  one_code_reg  <= cfg.data;
                    CFG_ZERO_CODE: zero_code_reg <= cfg.data;
                    default:       one_code_reg  <= one_code_reg;
                endcase
            end
            if (cmd.set_write)
            begin
                written_reg[set_addr_reg] <= 1'b1;
            end
            if (cmd.send_issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (words.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign led_ext   = {4'b0000, s1_led_reg};
    assign byte_data = s1_hit_reg ? ram_q : 8'h00;

    always_ff @(posedge clk)
    begin
        if (cmd.set_start)
        begin
            set_led_reg   <= first;
            set_end_reg   <= set_end;
            set_addr_reg  <= ADDR_W'(int'(first) * CHAN_COUNT + int'(in_color));
            set_value_reg <= in_value;
        end
        else if (cmd.set_write)
        begin
            set_led_reg  <= set_led_reg + GRP_W'(1);
            set_addr_reg <= set_addr_reg + ADDR_W'(CHAN_COUNT);
        end

        if (cmd.send_start)
        begin
            snd_led_reg  <= '0;
            snd_slot_reg <= SLOT_FIRST;
            snd_base_reg <= '0;
        end
        else if (cmd.send_issue)
        begin
            if (snd_slot_reg == SLOT_LAST)
            begin
                snd_slot_reg <= SLOT_FIRST;
                snd_led_reg  <= snd_led_reg + LED_W'(1);
                snd_base_reg <= snd_base_reg + ADDR_W'(CHAN_COUNT);
            end
            else
            begin
                snd_slot_reg <= snd_slot_reg + 2'd1;
            end
        end

        if (cmd.send_issue)
        begin
            s1_hit_reg  <= written_reg[rd_addr];
            s1_led_reg  <= snd_led_reg;
            s1_slot_reg <= snd_slot_reg;
            s1_last_reg <= snd_last;
        end

        // The word is encoded as it moves into the output register.
        if (advance)
        begin
            out_led_reg   <= led_ext[3:0];
            out_chan_reg  <= s1_slot_reg;
            out_bytes_reg <= encode_byte(byte_data, one_code_reg, zero_code_reg);
            out_last_reg  <= s1_last_reg;
        end
    end

    assign words.valid     = out_valid_reg;
    assign words.led_num   = out_led_reg;
    assign words.channel   = out_chan_reg;
    assign words.spi_bytes = out_bytes_reg;
    assign words.last      = out_last_reg;

endmodule

// ===== hdl/rgb_led_strip_spi_encoder.sv =====
`timescale 1ns / 1ps

// Holds a red, green and blue byte for each LED of the strip and turns the
// strip into SPI code words. A set word writes one channel of every LED in a
// group, one LED per cycle, and marks a refresh as pending. A tick word with
// a refresh pending sends 3 * NUM_LEDS words, LED 0 first in green, red, blue
// order, and flags the final one with last. Words come from the single read
// port of the color store at one per cycle while the sink keeps ready high;
// each word is read into the read stage and then encoded into the output
// register. A tick with nothing pending, or an unusable set, is accepted and
// changes nothing. The store needs no clearing pass after reset; unwritten
// channels read as zero. The one and zero code bytes are to be written
// through the configuration channel only while the block is idle, which the
// block itself does not enforce; they reset to 0xF8 and 0xE0.
module rgb_led_strip_spi_encoder #(
    parameter int NUM_LEDS       = rlsse_pkg::NUM_LEDS_DEF,
    parameter int LEDS_PER_GROUP = rlsse_pkg::LEDS_PER_GROUP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rlsse_in_if.sink    items,
    rlsse_out_if.source words,
    rlsse_cfg_if.sink   cfg
);

    import rlsse_pkg::*;

    rlsse_cmd_t    cmd;
    rlsse_status_t status;
    logic          in_ready;

    assign items.ready = in_ready;

    rlsse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_op    (items.op),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rlsse_dp #(
        .NUM_LEDS       (NUM_LEDS),
        .LEDS_PER_GROUP (LEDS_PER_GROUP)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_group (items.group),
        .in_color (items.color),
        .in_value (items.value),
        .cmd      (cmd),
        .status   (status),
        .cfg      (cfg),
        .words    (words)
    );

endmodule
